>>> src/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] HASH_UNIT  = 16'h0023;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [7:0]  CONT_MASK  = 8'b00111111;
  localparam logic [7:0]  KEEP_LEN1  = 8'h7F;
  localparam logic [7:0]  KEEP_LEN2  = 8'h1F;
  localparam logic [7:0]  KEEP_LEN3  = 8'h0F;
  localparam logic [7:0]  KEEP_LEN4  = 8'h07;

  // one run of bytes to be decoded as a whole, count is 1..4
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } job_t;

  // sequence length from the top five bits of a lead byte, 0 for a bad lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    case (b[7:3]) inside
      [5'd0:5'd15]:  len = 3'd1;
      [5'd16:5'd23]: len = 3'd0;
      [5'd24:5'd27]: len = 3'd2;
      [5'd28:5'd29]: len = 3'd3;
      5'd30:         len = 3'd4;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> src/utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// utf-8 to utf-16 transcoder
// input channel: drive in_byte and string_end with push; a beat is taken at a
//   clock edge with push high and full low. string_end marks the last byte of
//   a string, and a sequence cut short by it is decoded with '#' for the lead.
// result channel: while empty is low, code_unit and run_last show the oldest
//   waiting code unit; pop high at an edge with empty low takes the beat.
//   run_last is high on the last unit caused by one input byte.
// a byte that completes a run enters the run queue at its beat; the decoder
//   then loads the first unit of the run into the output register once that
//   register is free or being popped.
// throughput: one byte per cycle while each byte gives at most one unit and
//   pop keeps up; the back-end makes one code unit per cycle while the output
//   moves, so a surrogate pair or several '#' units hold back the next run.
// bytes that only extend a pending sequence give no result; they still wait
//   while the run queue is full.
// a receiver stall holds the output register; the two-entry run queue then
//   fills and full rises, so no beat is lost.
// reset (rst, synchronous) drops held bytes, queued runs and the output.
module utf8_to_utf16_transcoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        string_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      code_unit,
  output logic             run_last
);

  u8u16_pkg::job_t front_job;
  u8u16_pkg::job_t head_job;
  logic            accept;
  logic            job_push;
  logic            fifo_pop;
  logic            fifo_empty;
  logic            fifo_full;

  // run queue full blocks the input even for bytes that would only be held
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  // front: holds partial sequences, hands complete runs to the queue
  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .string_end (string_end),
    .job        (front_job),
    .job_push   (job_push)
  );

  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_push),
    .wr_job     (front_job),
    .rd_en      (fifo_pop),
    .rd_job     (head_job),
    .fifo_empty (fifo_empty),
    .fifo_full  (fifo_full)
  );

  // back: walks each run, one unit per cycle into the free output register
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .pop        (pop),
    .empty      (empty),
    .code_unit  (code_unit),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

>>> src/u8u16_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            string_end,
  output u8u16_pkg::job_t      job,
  output logic                 job_push
);

  logic [2:0][7:0] held_bytes;
  logic [1:0]      held_count;
  logic [2:0]      expected_length;

  logic [2:0] n;
  logic [2:0] need;
  logic       hold;

  assign n    = {1'b0, held_count} + 3'd1;
  assign need = (held_count == 2'd0) ? u8u16_pkg::lead_length(in_byte) : expected_length;
  assign hold = !string_end && (need > n) && (n <= 3'd3);

  assign job_push = accept && !hold;

  // held bytes first, then the incoming byte; slots past count are don't-care
  always_comb begin
    job.count    = n;
    job.bytes[0] = (held_count == 2'd0) ? in_byte : held_bytes[0];
    job.bytes[1] = (held_count == 2'd1) ? in_byte : held_bytes[1];
    job.bytes[2] = (held_count == 2'd2) ? in_byte : held_bytes[2];
    job.bytes[3] = in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
    end else if (accept) begin
      if (hold) begin
        held_count      <= n[1:0];
        expected_length <= need;
      end else begin
        held_count      <= 2'd0;
        expected_length <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold) begin
      held_bytes[held_count] <= in_byte;
    end
  end

endmodule

`default_nettype wire

>>> src/u8u16_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire u8u16_pkg::job_t wr_job,
  input  wire logic            rd_en,
  output u8u16_pkg::job_t      rd_job,
  output logic                 fifo_empty,
  output logic                 fifo_full
);

  u8u16_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign rd_job     = entries[rd_ptr];
  assign fifo_empty = (fill == 2'd0);
  assign fifo_full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_job;
  end

endmodule

`default_nettype wire

>>> src/u8u16_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire u8u16_pkg::job_t head,
  input  wire logic            fifo_empty,
  output logic                 fifo_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [15:0]          code_unit,
  output logic                 run_last
);

  // remainder of a run being worked through, always front-aligned
  logic [3:0][7:0] work_bytes;
  logic [2:0]      work_rem;
  logic            active;
  // second half of a surrogate pair
  logic            lo_pending;
  logic [15:0]     lo_unit;
  logic            lo_last;
  logic            out_valid;

  logic [3:0][7:0] s;
  logic [2:0]      rem;
  logic [2:0]      len;
  logic            bad;
  logic [20:0]     cp;
  logic [20:0]     u;
  logic            surr;
  logic [2:0]      step;
  logic [2:0]      rem_next;
  logic [3:0][7:0] shifted;
  logic            gen_ok;
  logic            take;

  assign s   = active ? work_bytes : head.bytes;
  assign rem = active ? work_rem : head.count;
  assign len = u8u16_pkg::lead_length(s[0]);
  assign bad = (len == 3'd0) || (len > rem);

  always_comb begin
    case (len)
      3'd1: cp = {14'd0, s[0][6:0] & u8u16_pkg::KEEP_LEN1[6:0]};
      3'd2: cp = {10'd0, s[0][4:0] & u8u16_pkg::KEEP_LEN2[4:0],
                  s[1][5:0] & u8u16_pkg::CONT_MASK[5:0]};
      3'd3: cp = {5'd0, s[0][3:0] & u8u16_pkg::KEEP_LEN3[3:0],
                  s[1][5:0] & u8u16_pkg::CONT_MASK[5:0],
                  s[2][5:0] & u8u16_pkg::CONT_MASK[5:0]};
      3'd4: cp = {s[0][2:0] & u8u16_pkg::KEEP_LEN4[2:0],
                  s[1][5:0] & u8u16_pkg::CONT_MASK[5:0],
                  s[2][5:0] & u8u16_pkg::CONT_MASK[5:0],
                  s[3][5:0] & u8u16_pkg::CONT_MASK[5:0]};
      default: cp = 21'd0;
    endcase
  end

  assign surr     = !bad && (cp[20:16] != 5'd0);
  assign u        = cp - u8u16_pkg::SUPP_BASE;
  assign step     = bad ? 3'd1 : len;
  assign rem_next = rem - step;

  always_comb begin
    case (step)
      3'd1:    shifted = {8'h00, s[3], s[2], s[1]};
      3'd2:    shifted = {8'h00, 8'h00, s[3], s[2]};
      3'd3:    shifted = {8'h00, 8'h00, 8'h00, s[3]};
      default: shifted = '0;
    endcase
  end

  assign gen_ok   = !out_valid || pop;
  assign take     = gen_ok && !lo_pending && (active || !fifo_empty);
  assign fifo_pop = take && !active;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      active     <= 1'b0;
      lo_pending <= 1'b0;
    end else if (gen_ok) begin
      if (lo_pending) begin
        out_valid  <= 1'b1;
        code_unit  <= lo_unit;
        run_last   <= lo_last;
        lo_pending <= 1'b0;
      end else if (take) begin
        out_valid  <= 1'b1;
        work_bytes <= shifted;
        work_rem   <= rem_next;
        active     <= (rem_next != 3'd0);
        if (surr) begin
          code_unit  <= u8u16_pkg::HI_SURR + {5'd0, u[20:10]};
          run_last   <= 1'b0;
          lo_pending <= 1'b1;
          lo_unit    <= u8u16_pkg::LO_SURR + {6'd0, u[9:0]};
          lo_last    <= (rem_next == 3'd0);
        end else begin
          code_unit <= bad ? u8u16_pkg::HASH_UNIT : cp[15:0];
          run_last  <= (rem_next == 3'd0);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // cycles with no beat on either side before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // random bytes sent after the directed table
  localparam int RANDOM_BEATS = 186;
  // settle time after the last expected unit, catches any extra unit
  localparam int TAIL_CYCLES = 12;

  // one expected beat on the result side
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } unit_beat_t;

  // one row of the directed table; a typed-in unit is used only where lit is set
  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    logic        lit;
    logic [15:0] unit;
  } stim_row_t;

  localparam int PLAN_ROWS = 24;
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    // extremes of a one-byte character
    '{8'h00, 1'b0, 1'b1, 16'h0000},
    '{8'h7F, 1'b1, 1'b1, 16'h007F},
    // bad leads: continuation bytes and the 0xf8-0xff range
    '{8'h80, 1'b0, 1'b1, u8u16_pkg::HASH_UNIT},
    '{8'hBF, 1'b0, 1'b1, u8u16_pkg::HASH_UNIT},
    '{8'hF8, 1'b0, 1'b1, u8u16_pkg::HASH_UNIT},
    '{8'hFF, 1'b1, 1'b1, u8u16_pkg::HASH_UNIT},
    // two-byte character
    '{8'hC3, 1'b0, 1'b0, 16'h0000},
    '{8'hA9, 1'b0, 1'b0, 16'h0000},
    // three-byte character
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 16'h0000},
    '{8'hAC, 1'b1, 1'b0, 16'h0000},
    // four-byte character, surrogate pair
    '{8'hF0, 1'b0, 1'b0, 16'h0000},
    '{8'h9F, 1'b0, 1'b0, 16'h0000},
    '{8'h98, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    // largest value a four-byte lead can carry
    '{8'hF7, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b1, 1'b0, 16'h0000},
    // string ends inside a three-byte sequence: lead and tail both give '#'
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b1, 1'b0, 16'h0000},
    // string ends inside a four-byte sequence, tail is plain ascii
    '{8'hF0, 1'b0, 1'b0, 16'h0000},
    '{8'h41, 1'b1, 1'b0, 16'h0000},
    // lone lead at the end of a string
    '{8'hC3, 1'b1, 1'b1, u8u16_pkg::HASH_UNIT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        string_end = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] code_unit;
  logic        run_last;

  utf8_to_utf16_transcoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .string_end (string_end),
    .empty      (empty),
    .pop        (pop),
    .code_unit  (code_unit),
    .run_last   (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: bytes of the pending sequence, how many, and its length
  logic [7:0]  pend_bytes [3];
  logic [1:0]  pend_count = 2'd0;
  logic [2:0]  pend_len = 3'd0;

  unit_beat_t  step_units [$];      // units caused by the byte just taken
  unit_beat_t  expected_units [$];  // units still owed by the block, oldest first
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          stall_cycles = 0;
  logic        send_calm = 1'b0;
  logic        take_calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // sequence length from the top bits of a lead, 0 when it cannot lead
  function automatic int seq_length(input logic [7:0] b);
    if (!b[7]) return 1;
    if (!b[6]) return 0;
    if (!b[5]) return 2;
    if (!b[4]) return 3;
    if (!b[3]) return 4;
    return 0;
  endfunction

  task automatic add_unit(input logic [15:0] u);
    step_units.push_back('{u, 1'b0});
  endtask

  // decode n bytes as one whole string, appending to step_units
  task automatic decode_string(input logic [3:0][7:0] run, input int n);
    int         pos;
    int         len;
    logic [20:0] cp;
    logic [20:0] off;
    logic [7:0]  keep;
    pos = 0;
    while (pos < n) begin
      len = seq_length(run[pos]);
      if (len == 0 || len > n - pos) begin
        // undecodable lead or not enough bytes left in the string
        add_unit(u8u16_pkg::HASH_UNIT);
        pos++;
      end else begin
        case (len)
          1: keep = u8u16_pkg::KEEP_LEN1;
          2: keep = u8u16_pkg::KEEP_LEN2;
          3: keep = u8u16_pkg::KEEP_LEN3;
          default: keep = u8u16_pkg::KEEP_LEN4;
        endcase
        cp = 21'(run[pos] & keep);
        for (int i = 1; i < len; i++)
          cp = (cp << 6) | 21'(run[pos + i] & u8u16_pkg::CONT_MASK);
        if (cp < u8u16_pkg::SUPP_BASE) begin
          add_unit(cp[15:0]);
        end else begin
          // surrogate pair, each unit kept to 16 bits
          off = cp - u8u16_pkg::SUPP_BASE;
          add_unit(u8u16_pkg::HI_SURR + 16'(off >> 10));
          add_unit(u8u16_pkg::LO_SURR + 16'(off[9:0]));
        end
        pos += len;
      end
    end
  endtask

  // advance the predictor by one taken byte; units land in step_units
  task automatic predict_byte(input logic [7:0] b, input logic e);
    logic [3:0][7:0] run;
    int              n;
    int              need;
    unit_beat_t      tail;
    step_units.delete();
    run = '0;
    n = 0;
    for (int i = 0; i < pend_count; i++) begin
      run[n] = pend_bytes[i];
      n++;
    end
    run[n] = b;
    n++;
    need = (pend_count == 0) ? seq_length(b) : int'(pend_len);
    if (!e && need > n && n <= 3) begin
      // sequence still short, hold the byte and give nothing
      pend_bytes[n - 1] = b;
      pend_count = 2'(n);
      pend_len = 3'(need);
      return;
    end
    decode_string(run, n);
    pend_count = 2'd0;
    pend_len = 3'd0;
    if (step_units.size() > 0) begin
      tail = step_units.pop_back();
      tail.last = 1'b1;
      step_units.push_back(tail);
    end
  endtask

  // send one beat after a random gap; predict once it is taken
  task automatic send_beat(input logic [7:0] b, input logic e, input logic lit,
                           input logic [15:0] lit_unit);
    int gap;
    if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    string_end <= e;
    do @(posedge clk); while (full !== 1'b0);
    beats_sent++;
    predict_byte(b, e);
    if (lit) begin
      // a typed-in unit stands in for the predicted one
      expected_units.push_back('{lit_unit, 1'b1});
    end else begin
      foreach (step_units[i]) expected_units.push_back(step_units[i]);
    end
  endtask

  // mostly well-formed characters with random payload bits, some noise and
  // some strings cut short inside a sequence
  task automatic send_char();
    logic [3:0][7:0] seq;
    int              kind;
    int              len;
    int              cut;
    logic            stop;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_beat(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 16'h0000);
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: seq[0] = {1'b0, 7'($urandom)};
      2: seq[0] = {3'b110, 5'($urandom)};
      3: seq[0] = {4'b1110, 4'($urandom)};
      default: seq[0] = {5'b11110, 3'($urandom)};
    endcase
    // continuation bytes are not checked by the block, so some are arbitrary
    for (int i = 1; i < 4; i++)
      seq[i] = ($urandom_range(0, 15) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
    cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
    stop = (cut < len) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < cut; i++) send_beat(seq[i], stop && (i == cut - 1), 1'b0, 16'h0000);
  endtask

  // result side: random pop gaps, check each beat against the oldest expectation
  initial begin : result_side
    unit_beat_t want;
    int         gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected unit %h last %b", code_unit, run_last));
      end else begin
        want = expected_units.pop_front();
        if (code_unit !== want.unit)
          report_mismatch($sformatf("code_unit %h, want %h", code_unit, want.unit));
        if (run_last !== want.last)
          report_mismatch($sformatf("run_last %b, want %b (unit %h)", run_last, want.last,
                                    want.unit));
      end
    end
  end

  // hang detector: cycles with no beat taken on either side
  always @(posedge clk) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("utf8_to_utf16_transcoder_top regression: fail");
      $finish;
    end
  end

  initial begin : byte_side
    logic paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed table first
    for (int r = 0; r < PLAN_ROWS; r++)
      send_beat(PLAN[r].b, PLAN[r].e, PLAN[r].lit, PLAN[r].unit);
    // then random characters
    while (beats_sent < PLAN_ROWS + RANDOM_BEATS) begin
      send_char();
      if (!paused && beats_sent >= PLAN_ROWS + RANDOM_BEATS / 2) begin
        // hold the input off until the block has drained every owed unit
        paused = 1'b1;
        push <= 1'b0;
        do @(posedge clk); while (expected_units.size() != 0);
      end
    end
    push <= 1'b0;
    do @(posedge clk); while (expected_units.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("utf8_to_utf16_transcoder_top regression: pass");
    end else begin
      $display("utf8_to_utf16_transcoder_top regression: fail");
    end
    $finish;
  end

endmodule
